// File: hdl/bmm_pkg.sv
// ----------------------------------------------------------------------------
// bmm_pkg: shared types for the bipartite matching unit
// Item structs, controller states and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package bmm_pkg;

    localparam int unsigned CFG_NUM_LEFT  = 0;
    localparam int unsigned CFG_NUM_RIGHT = 1;

    localparam logic KIND_EDGE  = 1'b0;
    localparam logic KIND_SOLVE = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [4:0] left_vertex;
        logic [4:0] right_vertex;
    } t_in_item;

    typedef struct packed {
        logic [4:0] pair_left;
        logic [4:0] pair_right;
        logic       pair_valid;
        logic [5:0] match_count;
        logic       edge_dropped;
        logic       last;
    } t_out_item;

    typedef enum logic [4:0] {
        ST_IDLE,      // takes edges and solve items
        ST_ROOT,      // start search for root vertex
        ST_GF_RD,     // grab_free: issue list read
        ST_GF_CHK,    // grab_free: list data back, check right partner
        ST_GF_DONE,   // grab_free ended (found or exhausted)
        ST_WK_TOP,    // walk: read top frame
        ST_WK_RD,     // walk: issue list read for frame
        ST_WK_CHK,    // walk: inspect neighbour
        ST_UN_RD,     // unwind: read list entry next-1
        ST_UN_LINK,   // unwind: link pair, pop
        ST_NEXT_ROOT,
        ST_CNT,       // count matched
        ST_EMIT,      // find next matched left
        ST_OUT,       // hold result item
        ST_CLR        // clear graph
    } t_state;

endpackage
`default_nettype wire

// File: hdl/bipartite_max_matching_unit.sv
// ----------------------------------------------------------------------------
// bipartite_max_matching_unit
// Kuhn augmenting-path maximum bipartite matching over loaded edge lists.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction
//  in      | i_in_valid/o_in_ready/i_in_item | edge or solve item into block
//  out     | o_out_valid/i_out_ready/o_out_item | matched pair items out
//  cfg     | i_cfg_valid/o_cfg_ready/i_cfg_index/i_cfg_data | register writes
//
//  Each edge item is a single write into the neighbour memory.
//  A solve holds o_in_ready low until the matching is out and cleared: the
//  augmenting-path search from each root, then counting of matched left
//  vertices, an emission scan over the left vertices with one result item
//  per matched pair, and clearing. Reset is synchronous, active low.
//  A result holds while i_out_ready is low; the emission scan waits for it.
// ----------------------------------------------------------------------------
`default_nettype none
module bipartite_max_matching_unit #(
    parameter int N_LEFT     = 32,
    parameter int N_RIGHT    = 32,
    parameter int MAX_DEGREE = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire bmm_pkg::t_in_item i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output bmm_pkg::t_out_item   o_out_item,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [0:0]            i_cfg_index,
    input  wire [5:0]            i_cfg_data
);
    localparam int LW = (N_LEFT > 1) ? $clog2(N_LEFT) : 1;
    localparam int RW = (N_RIGHT > 1) ? $clog2(N_RIGHT) : 1;
    localparam int CW = $clog2(MAX_DEGREE + 1);
    localparam int SW = $clog2(N_LEFT + 1);
    localparam int MD = N_LEFT * MAX_DEGREE;
    localparam int AW = (MD > 1) ? $clog2(MD) : 1;

    // neighbour memory, one write and one registered read per cycle
    logic [RW-1:0] r_nbr [MD];
    logic [RW-1:0] r_nbr_q;
    logic          w_nbr_we;
    logic [AW-1:0] w_nbr_wa, w_nbr_ra;

    // stack memory: frame vertex and next index
    logic [LW-1:0] r_stk_v [N_LEFT];
    logic [CW-1:0] r_stk_n [N_LEFT];
    logic [LW-1:0] r_stk_vq;
    logic [CW-1:0] r_stk_nq;
    logic          w_stk_we;
    logic [LW-1:0] w_stk_wa, w_stk_ra;
    logic [LW-1:0] w_stk_wv;
    logic [CW-1:0] w_stk_wn;

    // small per-vertex bookkeeping in flip-flops
    logic [CW-1:0] r_deg   [N_LEFT];
    logic          r_lmat  [N_LEFT];
    logic [RW-1:0] r_lpart [N_LEFT];
    logic          r_rmat  [N_RIGHT];
    logic [LW-1:0] r_rpart [N_RIGHT];
    logic          r_vis   [N_LEFT];

    logic [5:0] r_num_left, r_num_right;
    logic       r_drop;
    bmm_pkg::t_state r_st, n_st;

    logic [SW-1:0] r_root;     // root / scan index
    logic [LW-1:0] r_gv;       // vertex for grab_free
    logic [CW-1:0] r_gi;       // grab_free index
    logic          r_gf_ok;
    logic          r_gf_root;  // grab_free called for root
    logic [SW-1:0] r_sp;
    logic          r_ok;
    logic [5:0]    r_cnt;
    logic [SW-1:0] r_nl;

    logic [SW-1:0] w_nl_eff;
    logic [5:0]    w_nr_eff;
    always_comb begin
        w_nl_eff = (int'(r_num_left) > N_LEFT) ? SW'(N_LEFT) : SW'(r_num_left);
        w_nr_eff = (int'(r_num_right) > N_RIGHT) ? 6'(N_RIGHT) : r_num_right;
    end

    wire w_in_acc  = i_in_valid && o_in_ready;
    wire w_edge    = w_in_acc && (i_in_item.kind == bmm_pkg::KIND_EDGE);
    wire w_solve   = w_in_acc && (i_in_item.kind == bmm_pkg::KIND_SOLVE);
    wire [LW-1:0] w_el = LW'(i_in_item.left_vertex);
    wire [RW-1:0] w_er = RW'(i_in_item.right_vertex);
    wire w_edge_ok = ({1'b0, i_in_item.left_vertex} < 6'(w_nl_eff))
                  && ({1'b0, i_in_item.right_vertex} < w_nr_eff)
                  && (r_deg[w_el] < CW'(MAX_DEGREE));

    wire [LW-1:0] w_root = r_root[LW-1:0];
    wire [RW-1:0] w_y    = r_nbr_q;
    wire [LW-1:0] w_z    = r_rpart[w_y];
    wire          w_zm   = r_rmat[w_y];

    assign o_in_ready  = (r_st == bmm_pkg::ST_IDLE);
    assign o_cfg_ready = (r_st == bmm_pkg::ST_IDLE);

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            bmm_pkg::ST_IDLE:
                if (w_solve) n_st = bmm_pkg::ST_ROOT;
            bmm_pkg::ST_ROOT:
                n_st = (r_root >= r_nl) ? bmm_pkg::ST_CNT : bmm_pkg::ST_GF_RD;
            bmm_pkg::ST_GF_RD:
                n_st = (r_gi < r_deg[r_gv]) ? bmm_pkg::ST_GF_CHK : bmm_pkg::ST_GF_DONE;
            bmm_pkg::ST_GF_CHK:
                n_st = !r_rmat[w_y] ? bmm_pkg::ST_GF_DONE : bmm_pkg::ST_GF_RD;
            bmm_pkg::ST_GF_DONE:
                if (r_gf_root)
                    n_st = r_gf_ok ? bmm_pkg::ST_NEXT_ROOT : bmm_pkg::ST_WK_TOP;
                else
                    n_st = bmm_pkg::ST_WK_TOP;
            bmm_pkg::ST_WK_TOP:
                n_st = (r_sp == '0) ? bmm_pkg::ST_NEXT_ROOT : bmm_pkg::ST_WK_RD;
            bmm_pkg::ST_WK_RD:
                if (r_ok) n_st = bmm_pkg::ST_UN_RD;
                else if (r_stk_nq < r_deg[r_stk_vq]) n_st = bmm_pkg::ST_WK_CHK;
                else n_st = bmm_pkg::ST_WK_TOP;
            bmm_pkg::ST_WK_CHK:
                if (w_zm && !r_vis[w_z]) n_st = bmm_pkg::ST_GF_RD;
                else n_st = bmm_pkg::ST_WK_RD;
            bmm_pkg::ST_UN_RD:   n_st = bmm_pkg::ST_UN_LINK;
            bmm_pkg::ST_UN_LINK: n_st = bmm_pkg::ST_WK_TOP;
            bmm_pkg::ST_NEXT_ROOT: n_st = bmm_pkg::ST_ROOT;
            bmm_pkg::ST_CNT:
                n_st = (r_root >= r_nl) ? bmm_pkg::ST_EMIT : bmm_pkg::ST_CNT;
            bmm_pkg::ST_EMIT:
                if (r_root >= r_nl) n_st = (r_cnt == '0) ? bmm_pkg::ST_OUT : bmm_pkg::ST_CLR;
                else if (r_lmat[w_root]) n_st = bmm_pkg::ST_OUT;
            bmm_pkg::ST_OUT:
                if (i_out_ready)
                    n_st = o_out_item.last ? bmm_pkg::ST_CLR : bmm_pkg::ST_EMIT;
            bmm_pkg::ST_CLR: n_st = bmm_pkg::ST_IDLE;
            default: n_st = bmm_pkg::ST_IDLE;
        endcase
    end

    // memory addressing (outputs of the sequencer)
    always_comb begin
        w_nbr_we = w_edge && w_edge_ok;
        w_nbr_wa = AW'(w_el) * AW'(MAX_DEGREE) + AW'(r_deg[w_el]);
        w_nbr_ra = AW'(r_gv) * AW'(MAX_DEGREE) + AW'(r_gi);
        w_stk_ra = LW'(r_sp - SW'(1));
        w_stk_we = 1'b0;
        w_stk_wa = w_stk_ra;
        w_stk_wv = r_stk_vq;
        w_stk_wn = r_stk_nq;
        unique case (r_st)
            bmm_pkg::ST_WK_RD:
                if (!r_ok) begin
                    w_nbr_ra = AW'(r_stk_vq) * AW'(MAX_DEGREE) + AW'(r_stk_nq);
                    // pre-increment next in the stored frame
                    if (r_stk_nq < r_deg[r_stk_vq]) begin
                        w_stk_we = 1'b1;
                        w_stk_wn = r_stk_nq + CW'(1);
                    end
                end
            bmm_pkg::ST_UN_RD:
                w_nbr_ra = AW'(r_stk_vq) * AW'(MAX_DEGREE) + AW'(r_stk_nq - CW'(1));
            bmm_pkg::ST_GF_DONE:
                if (r_gf_root ? !r_gf_ok : (!r_gf_ok && r_sp < SW'(N_LEFT))) begin
                    w_stk_we = 1'b1;
                    w_stk_wa = LW'(r_sp);
                    w_stk_wv = r_gv;
                    w_stk_wn = '0;
                end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_nbr_we) r_nbr[w_nbr_wa] <= w_er;
        r_nbr_q <= r_nbr[w_nbr_ra];
        if (w_stk_we) begin
            r_stk_v[w_stk_wa] <= w_stk_wv;
            r_stk_n[w_stk_wa] <= w_stk_wn;
        end
        r_stk_vq <= r_stk_v[w_stk_ra];
        r_stk_nq <= r_stk_n[w_stk_ra];
    end

    // result item
    always_comb begin
        o_out_valid = (r_st == bmm_pkg::ST_OUT);
        o_out_item.pair_left    = 5'(w_root);
        o_out_item.pair_right   = 5'(r_lpart[w_root]);
        o_out_item.pair_valid   = (r_cnt != '0);
        o_out_item.match_count  = r_cnt;
        o_out_item.edge_dropped = r_drop;
        o_out_item.last         = 1'b1;
        if (r_cnt == '0) begin
            o_out_item.pair_left  = '0;
            o_out_item.pair_right = '0;
        end else begin
            for (int k = 0; k < N_LEFT; k++)
                if (k > int'(r_root) && k < int'(r_nl) && r_lmat[k])
                    o_out_item.last = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= bmm_pkg::ST_IDLE;
            r_num_left <= 6'd32;
            r_num_right <= 6'd32;
            r_drop <= 1'b0;
            r_ok <= 1'b0;
            r_sp <= '0;
            r_root <= '0;
            r_cnt <= '0;
            for (int k = 0; k < N_LEFT; k++) begin
                r_deg[k] <= '0;
                r_lmat[k] <= 1'b0;
                r_vis[k] <= 1'b0;
            end
            for (int k = 0; k < N_RIGHT; k++) r_rmat[k] <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == 1'(bmm_pkg::CFG_NUM_LEFT)) r_num_left <= i_cfg_data;
                else r_num_right <= i_cfg_data;
            end
            if (w_edge) begin
                if (w_edge_ok) r_deg[w_el] <= r_deg[w_el] + CW'(1);
                else r_drop <= 1'b1;
            end
            unique case (r_st)
                bmm_pkg::ST_IDLE: begin
                    r_root <= '0;
                    r_nl <= w_nl_eff;
                    r_cnt <= '0;
                    for (int k = 0; k < N_LEFT; k++) r_vis[k] <= 1'b0;
                end
                bmm_pkg::ST_ROOT:
                    if (r_root < r_nl) begin
                        // visit marks are per round: cleared between roots
                        r_vis[w_root] <= 1'b1;
                        r_gv <= w_root;
                        r_gi <= '0;
                        r_gf_ok <= 1'b0;
                        r_gf_root <= 1'b1;
                        r_sp <= '0;
                        r_ok <= 1'b0;
                    end else begin
                        r_root <= '0;
                    end
                bmm_pkg::ST_GF_RD: ;
                bmm_pkg::ST_GF_CHK:
                    if (!r_rmat[w_y]) begin
                        r_lmat[r_gv] <= 1'b1;
                        r_lpart[r_gv] <= w_y;
                        r_rmat[w_y] <= 1'b1;
                        r_rpart[w_y] <= r_gv;
                        r_gf_ok <= 1'b1;
                    end else begin
                        r_gi <= r_gi + CW'(1);
                    end
                bmm_pkg::ST_GF_DONE: begin
                    if (r_gf_root) begin
                        if (!r_gf_ok) r_sp <= SW'(1);
                    end else if (r_gf_ok) begin
                        r_ok <= 1'b1;
                    end else if (r_sp < SW'(N_LEFT)) begin
                        r_sp <= r_sp + SW'(1);
                    end
                    r_gf_root <= 1'b0;
                end
                bmm_pkg::ST_WK_TOP: ;
                bmm_pkg::ST_WK_RD:
                    if (!r_ok && !(r_stk_nq < r_deg[r_stk_vq])) r_sp <= r_sp - SW'(1);
                bmm_pkg::ST_WK_CHK:
                    if (w_zm && !r_vis[w_z]) begin
                        r_vis[w_z] <= 1'b1;
                        r_gv <= w_z;
                        r_gi <= '0;
                        r_gf_ok <= 1'b0;
                    end
                bmm_pkg::ST_UN_RD: ;
                bmm_pkg::ST_UN_LINK: begin
                    r_lmat[r_stk_vq] <= 1'b1;
                    r_lpart[r_stk_vq] <= w_y;
                    r_rmat[w_y] <= 1'b1;
                    r_rpart[w_y] <= r_stk_vq;
                    r_sp <= r_sp - SW'(1);
                end
                bmm_pkg::ST_NEXT_ROOT: begin
                    r_root <= r_root + SW'(1);
                    for (int k = 0; k < N_LEFT; k++) r_vis[k] <= 1'b0;
                end
                bmm_pkg::ST_CNT:
                    if (r_root < r_nl) begin
                        if (r_lmat[w_root]) r_cnt <= r_cnt + 6'd1;
                        r_root <= r_root + SW'(1);
                    end else begin
                        r_root <= '0;
                    end
                bmm_pkg::ST_EMIT:
                    if (r_root < r_nl && !r_lmat[w_root]) r_root <= r_root + SW'(1);
                bmm_pkg::ST_OUT:
                    if (i_out_ready) r_root <= r_root + SW'(1);
                bmm_pkg::ST_CLR: begin
                    r_drop <= 1'b0;
                    for (int k = 0; k < N_LEFT; k++) begin
                        r_deg[k] <= '0;
                        r_lmat[k] <= 1'b0;
                    end
                    for (int k = 0; k < N_RIGHT; k++) r_rmat[k] <= 1'b0;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for bipartite_max_matching_unit
// Loads random and directed graphs, solves them, and checks every matched
// pair item against a behavioral Kuhn matcher kept inside the bench.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;

    localparam int NL = 32;
    localparam int NR = 32;
    localparam int MAXDEG = 32;
    localparam int UNMATCHED = -1;
    localparam int CYCLE_LIMIT = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    bmm_pkg::t_in_item i_in_item = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    bmm_pkg::t_out_item o_out_item;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [0:0] i_cfg_index = '0;
    logic [5:0] i_cfg_data = '0;

    bipartite_max_matching_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------- matcher state kept by the bench ----------------
    int adj [NL][MAXDEG];
    int deg [NL];
    int lmate [NL];
    int rmate [NR];
    int seen [NL];
    bit dropped;
    logic [5:0] reg_left = 6'd32;
    logic [5:0] reg_right = 6'd32;

    bmm_pkg::t_out_item pending_pairs[$];
    int fail_cnt = 0;
    int pair_cnt = 0;
    int solve_cnt = 0;
    int edge_cnt = 0;
    bit hold_rx = 0;       // forces a long receiver stall
    int cycle_cnt = 0;

    function automatic int used_left();
        return (reg_left > NL) ? NL : int'(reg_left);
    endfunction

    function automatic int used_right();
        return (reg_right > NR) ? NR : int'(reg_right);
    endfunction

    function automatic void wipe_graph();
        for (int i = 0; i < NL; i++) begin
            deg[i] = 0;
            seen[i] = 0;
            lmate[i] = UNMATCHED;
        end
        for (int i = 0; i < NR; i++) rmate[i] = UNMATCHED;
        dropped = 0;
    endfunction

    function automatic void pair_up(int l, int r);
        lmate[l] = r;
        rmate[r] = l;
    endfunction

    // first free neighbour in list order
    function automatic bit take_free(int v);
        for (int i = 0; i < deg[v]; i++) begin
            if (rmate[adj[v][i]] == UNMATCHED) begin
                pair_up(v, adj[v][i]);
                return 1;
            end
        end
        return 0;
    endfunction

    // explicit-stack augmenting search from one root
    function automatic void search_from(int root, int mark);
        int stk_v [NL];
        int stk_n [NL];
        int sp;
        bit ok;
        bit went;
        int v;
        int y;
        int z;
        sp = 0;
        ok = 0;
        seen[root] = mark;
        if (take_free(root)) return;
        stk_v[0] = root;
        stk_n[0] = 0;
        sp = 1;
        while (sp > 0) begin
            v = stk_v[sp-1];
            went = 0;
            if (ok) begin
                pair_up(v, adj[v][stk_n[sp-1]-1]);
                sp--;
                continue;
            end
            while (stk_n[sp-1] < deg[v]) begin
                y = adj[v][stk_n[sp-1]];
                z = rmate[y];
                stk_n[sp-1]++;
                if (z != UNMATCHED && seen[z] != mark) begin
                    seen[z] = mark;
                    if (take_free(z)) ok = 1;
                    else if (sp < NL) begin
                        stk_v[sp] = z;
                        stk_n[sp] = 0;
                        sp++;
                    end
                    went = 1;
                    break;
                end
            end
            if (!went) sp--;
        end
    endfunction

    // apply one accepted item to the bench matcher
    function automatic void predict_matching(bmm_pkg::t_in_item it);
        int nl;
        int total;
        bmm_pkg::t_out_item o;
        nl = used_left();
        if (it.kind == bmm_pkg::KIND_EDGE) begin
            if (it.left_vertex >= nl || it.right_vertex >= used_right()
                || deg[it.left_vertex] >= MAXDEG) begin
                dropped = 1;
            end else begin
                adj[it.left_vertex][deg[it.left_vertex]] = it.right_vertex;
                deg[it.left_vertex]++;
            end
            return;
        end
        for (int i = 0; i < nl; i++) search_from(i, i + 1);
        total = 0;
        for (int i = 0; i < nl; i++) if (lmate[i] != UNMATCHED) total++;
        for (int i = 0; i < nl; i++) begin
            if (lmate[i] == UNMATCHED) continue;
            o.pair_left = i[4:0];
            o.pair_right = lmate[i][4:0];
            o.pair_valid = 1'b1;
            o.match_count = total[5:0];
            o.edge_dropped = dropped;
            o.last = 1'b0;
            pending_pairs = {pending_pairs, o};
        end
        if (total == 0) begin
            o = '0;
            o.edge_dropped = dropped;
            o.last = 1'b1;
            pending_pairs = {pending_pairs, o};
        end else begin
            pending_pairs[pending_pairs.size()-1].last = 1'b1;
        end
        wipe_graph();
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------- drivers ----------------
    // valid stays up across back-to-back items; it drops only for a gap
    task automatic send_item(bmm_pkg::t_in_item it);
        int g;
        g = pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_in_item <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_matching(it);
        if (it.kind == bmm_pkg::KIND_EDGE) edge_cnt++;
        else solve_cnt++;
        @(negedge i_clk);
    endtask

    task automatic send_edge(int l, int r);
        bmm_pkg::t_in_item it;
        it.kind = bmm_pkg::KIND_EDGE;
        it.left_vertex = l[4:0];
        it.right_vertex = r[4:0];
        send_item(it);
    endtask

    task automatic send_solve();
        bmm_pkg::t_in_item it;
        it.kind = bmm_pkg::KIND_SOLVE;
        it.left_vertex = 5'($urandom);
        it.right_vertex = 5'($urandom);
        send_item(it);
    endtask

    // wait until every pair is out, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_pairs.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(int idx, logic [5:0] val);
        @(negedge i_clk);
        i_cfg_index <= idx[0:0];
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == bmm_pkg::CFG_NUM_LEFT) reg_left = val;
        else if (idx == bmm_pkg::CFG_NUM_RIGHT) reg_right = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver: random ready, plus forced hold-off
    always @(negedge i_clk) begin
        if (hold_rx) i_out_ready <= 1'b0;
        else i_out_ready <= (pick_gap() == 0);
    end

    // result checker
    always @(posedge i_clk) begin
        bmm_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pairs.size() == 0) begin
                $error("unexpected result item %p", o_out_item);
                fail_cnt++;
            end else begin
                want = pending_pairs.pop_front();
                pair_cnt++;
                if (o_out_item.pair_left !== want.pair_left) begin
                    $error("pair_left exp %0d got %0d", want.pair_left,
                           o_out_item.pair_left);
                    fail_cnt++;
                end
                if (o_out_item.pair_right !== want.pair_right) begin
                    $error("pair_right exp %0d got %0d", want.pair_right,
                           o_out_item.pair_right);
                    fail_cnt++;
                end
                if (o_out_item.pair_valid !== want.pair_valid) begin
                    $error("pair_valid exp %0d got %0d", want.pair_valid,
                           o_out_item.pair_valid);
                    fail_cnt++;
                end
                if (o_out_item.match_count !== want.match_count) begin
                    $error("match_count exp %0d got %0d", want.match_count,
                           o_out_item.match_count);
                    fail_cnt++;
                end
                if (o_out_item.edge_dropped !== want.edge_dropped) begin
                    $error("edge_dropped exp %0d got %0d", want.edge_dropped,
                           o_out_item.edge_dropped);
                    fail_cnt++;
                end
                if (o_out_item.last !== want.last) begin
                    $error("last exp %0d got %0d", want.last, o_out_item.last);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------- tests ----------------
    // corner cases: empty graph, extremes, dups, drops, fully-loaded vertex
    task automatic test_directed();
        send_solve();                      // empty matching
        send_edge(0, 0);
        send_edge(31, 31);
        send_edge(31, 0);
        send_edge(0, 0);                   // duplicate
        send_solve();
        send_edge(0, 5);                   // re-route needed: 1 steals 5
        send_edge(0, 6);
        send_edge(1, 5);
        send_edge(2, 5);
        send_edge(2, 6);
        send_solve();
        for (int i = 0; i < MAXDEG; i++) send_edge(3, i);
        send_edge(3, 7);                   // beyond max degree: dropped
        send_edge(4, 7);
        send_solve();
        drain();
    endtask

    // registers at extremes, including zero and values above the vertex count
    task automatic test_register_sweep();
        logic [5:0] lset [5] = '{6'd0, 6'd1, 6'd63, 6'd5, 6'd32};
        logic [5:0] rset [5] = '{6'd63, 6'd0, 6'd1, 6'd3, 6'd32};
        for (int k = 0; k < 5; k++) begin
            write_reg(bmm_pkg::CFG_NUM_LEFT, lset[k]);
            write_reg(bmm_pkg::CFG_NUM_RIGHT, rset[k]);
            for (int j = 0; j < 8; j++)
                send_edge($urandom_range(0, 31), $urandom_range(0, 31));
            send_solve();
            drain();
        end
        // change num_left between loading and solving
        for (int j = 0; j < 10; j++)
            send_edge($urandom_range(0, 31), $urandom_range(0, 31));
        drain();
        write_reg(bmm_pkg::CFG_NUM_LEFT, 6'd6);
        send_solve();
        drain();
        write_reg(bmm_pkg::CFG_NUM_LEFT, 6'd32);
    endtask

    // long receiver hold-off while edges and solves keep coming
    task automatic test_backpressure();
        hold_rx = 1;
        fork
            begin
                repeat (400) @(negedge i_clk);
                hold_rx = 0;
            end
            begin
                for (int s = 0; s < 3; s++) begin
                    for (int j = 0; j < 6; j++)
                        send_edge($urandom_range(0, 7), $urandom_range(0, 7));
                    send_solve();
                end
            end
        join
        drain();
    endtask

    // random graphs, mostly small and dense so augmenting paths get long
    task automatic test_random_graphs();
        int sent;
        int nl;
        int nr;
        int ne;
        sent = 0;
        while (sent < 90) begin
            nl = ($urandom_range(0, 9) == 0) ? 32 : $urandom_range(2, 10);
            nr = ($urandom_range(0, 9) == 0) ? 32 : $urandom_range(2, 10);
            ne = $urandom_range(1, (3 * nl > 24) ? 24 : 3 * nl);
            for (int j = 0; j < ne; j++) begin
                if ($urandom_range(0, 19) == 0)
                    send_edge($urandom_range(0, 31), $urandom_range(0, 31));
                else
                    send_edge($urandom_range(0, nl - 1), $urandom_range(0, nr - 1));
                sent++;
            end
            send_solve();
            sent++;
            if ($urandom_range(0, 3) == 0) drain();    // sender waits for all
        end
        drain();
    endtask

    initial begin
        wipe_graph();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_register_sweep();
        test_backpressure();
        test_random_graphs();
        $display("Ran %0d edges and %0d solves, %0d result items checked.",
                 edge_cnt, solve_cnt, pair_cnt);
        if (fail_cnt == 0 && pending_pairs.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire
